>>> hdl/hsv_to_rgb_converter_top_defines.svh
// assertion macros for the hsv to rgb converter checker
// needs clk_i and rst_ni in the scope that uses them
`ifndef HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// property checked on every rising edge outside reset
`define HSV2RGB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every rising edge, reset included
`define HSV2RGB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/hsv2rgb_pkg.sv
// package for the hsv to rgb converter: beat types, constants and the divide by 255 helper
// no dependencies
package hsv2rgb_pkg;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       invalid;
  } rgb_t;

  localparam logic [8:0]  HueLimit   = 9'd360;
  localparam logic [8:0]  Hue60      = 9'd60;
  localparam logic [8:0]  Hue120     = 9'd120;
  localparam logic [8:0]  Hue180     = 9'd180;
  localparam logic [8:0]  Hue240     = 9'd240;
  localparam logic [8:0]  Hue300     = 9'd300;
  localparam logic [7:0]  FullScale  = 8'd255;
  localparam logic [6:0]  SectorDeg  = 7'd60;
  localparam logic [13:0] MidDen     = 14'd15300;
  localparam logic [21:0] MidHalf    = 22'd7650;
  // ceil(2^24 / 15), exact for quotients of values below 2^20
  localparam logic [20:0] Recip15    = 21'd1118482;
  localparam int unsigned Recip15Sh  = 24;

  localparam logic [2:0] Sector0 = 3'd0;
  localparam logic [2:0] Sector1 = 3'd1;
  localparam logic [2:0] Sector2 = 3'd2;
  localparam logic [2:0] Sector3 = 3'd3;
  localparam logic [2:0] Sector4 = 3'd4;
  localparam logic [2:0] Sector5 = 3'd5;

  // floor(x / 255) for x up to 65279
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

>>> hdl/hsv_to_rgb_converter_top.sv
// Five-stage pipeline from input beat to output beat.
// Throughput one beat per cycle; the whole pipeline advances together and holds
// while the output register is full and not taken.
// Stage 4 holds the 20x21 reciprocal multiply that divides by 15.
// Reset clears all stage valid bits; data registers are not reset.
// top level of the hsv to rgb converter, depends on hsv2rgb_pkg
module hsv_to_rgb_converter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hsv2rgb_pkg::hsv_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsv2rgb_pkg::rgb_t  out_data_o
);
  import hsv2rgb_pkg::*;

  logic        en;
  logic [4:0]  vld_q;

  // stage 1 comb
  logic [8:0]  hue;
  logic [8:0]  m120_w;
  logic [6:0]  m120;
  logic [6:0]  t_full;
  logic [2:0]  sector_d;
  logic        inv_d;

  // stage 1 regs, and the sector, invalid and brightness regs of stages 2 to 4
  logic [2:0]  s1_sector_q, s2_sector_q, s3_sector_q, s4_sector_q;
  logic        s1_inv_q, s2_inv_q, s3_inv_q, s4_inv_q;
  logic [7:0]  s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [5:0]  s1_t_q;
  logic [15:0] s1_p_q;
  logic [15:0] s1_sv_q;

  // stage 2
  logic [21:0] s2_svt_q;
  logic [21:0] s2_v15300_q;
  logic [7:0]  s2_small_q, s3_small_q, s4_small_q;
  logic [15:0] p_rnd;

  // stage 3
  logic [21:0] x_w;
  logic [19:0] s3_y_q;

  // stage 4
  logic [40:0] prod_w;
  logic [15:0] s4_z_q;

  // stage 5
  logic [7:0]  mid;
  rgb_t        out_d, out_q;

  assign en         = !vld_q[4] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[4];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  // sector and distance of the hue from the nearest of 60, 180 and 300 degrees
  always_comb begin
    hue   = in_data_i.hue;
    inv_d = hue > HueLimit;
    if (hue >= HueLimit) begin
      m120_w = hue - HueLimit;
    end else if (hue >= Hue240) begin
      m120_w = hue - Hue240;
    end else if (hue >= Hue120) begin
      m120_w = hue - Hue120;
    end else begin
      m120_w = hue;
    end
    m120 = m120_w[6:0];
    if (m120 >= SectorDeg) begin
      t_full = m120 - SectorDeg;
    end else begin
      t_full = SectorDeg - m120;
    end
    if (hue >= Hue300) begin
      sector_d = Sector5;
    end else if (hue >= Hue240) begin
      sector_d = Sector4;
    end else if (hue >= Hue180) begin
      sector_d = Sector3;
    end else if (hue >= Hue120) begin
      sector_d = Sector2;
    end else if (hue >= Hue60) begin
      sector_d = Sector1;
    end else begin
      sector_d = Sector0;
    end
  end

  assign p_rnd  = s1_p_q + 16'd127;
  assign x_w    = s2_v15300_q - s2_svt_q + MidHalf;
  assign prod_w = {1'b0, s3_y_q} * {20'd0, Recip15};
  assign mid    = div255(s4_z_q);

  always_comb begin
    out_d = '0;
    if (s4_inv_q) begin
      out_d.invalid = 1'b1;
    end else begin
      case (s4_sector_q)
        Sector0: begin
          out_d.red = s4_v_q;      out_d.green = mid;        out_d.blue = s4_small_q;
        end
        Sector1: begin
          out_d.red = mid;         out_d.green = s4_v_q;     out_d.blue = s4_small_q;
        end
        Sector2: begin
          out_d.red = s4_small_q;  out_d.green = s4_v_q;     out_d.blue = mid;
        end
        Sector3: begin
          out_d.red = s4_small_q;  out_d.green = mid;        out_d.blue = s4_v_q;
        end
        Sector4: begin
          out_d.red = mid;         out_d.green = s4_small_q; out_d.blue = s4_v_q;
        end
        default: begin
          out_d.red = s4_v_q;      out_d.green = s4_small_q; out_d.blue = mid;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sector_q <= sector_d;
      s1_inv_q    <= inv_d;
      s1_v_q      <= in_data_i.brightness;
      s1_t_q      <= t_full[5:0];
      s1_p_q      <= {8'd0, in_data_i.brightness}
                     * {8'd0, FullScale - in_data_i.saturation};
      s1_sv_q     <= {8'd0, in_data_i.brightness} * {8'd0, in_data_i.saturation};

      s2_sector_q <= s1_sector_q;
      s2_inv_q    <= s1_inv_q;
      s2_v_q      <= s1_v_q;
      s2_svt_q    <= {6'd0, s1_sv_q} * {16'd0, s1_t_q};
      s2_v15300_q <= {14'd0, s1_v_q} * {8'd0, MidDen};
      s2_small_q  <= div255(p_rnd);

      s3_sector_q <= s2_sector_q;
      s3_inv_q    <= s2_inv_q;
      s3_v_q      <= s2_v_q;
      s3_small_q  <= s2_small_q;
      s3_y_q      <= x_w[21:2];

      s4_sector_q <= s3_sector_q;
      s4_inv_q    <= s3_inv_q;
      s4_v_q      <= s3_v_q;
      s4_small_q  <= s3_small_q;
      s4_z_q      <= prod_w[Recip15Sh+15:Recip15Sh];

      out_q       <= out_d;
    end
  end

endmodule

>>> hdl/hsv2rgb_checker.sv
// port-level checker for the hsv to rgb converter, bound to the top level
// depends on hsv2rgb_pkg and hsv_to_rgb_converter_top_defines.svh
`include "hsv_to_rgb_converter_top_defines.svh"

module hsv2rgb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input hsv2rgb_pkg::rgb_t out_data_o
);
  import hsv2rgb_pkg::*;

  `HSV2RGB_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "output beat dropped")
  `HSV2RGB_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o), "output beat changed while stalled")
  `HSV2RGB_ASSERT(a_invalid_zero, out_valid_o && out_data_o.invalid |-> out_data_o.red == 8'd0 && out_data_o.green == 8'd0 && out_data_o.blue == 8'd0, "invalid beat with colour")
  `HSV2RGB_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input stalled with empty output")

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (.*);
